>>> rtl/skrt_pkg.sv
// Shared constants, codes and types of the sorted keyed record table.
`timescale 1ns / 1ps

package skrt_pkg;

    // Table size and result limits.
    localparam int CAPACITY     = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Field widths.
    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 16;
    localparam int IQTY_W   = 21;
    localparam int IPRICE_W = 24;
    localparam int STATUS_W = 3;
    localparam int QTY_W    = 20;
    localparam int PRICE_W  = 23;
    localparam int ENTRY_W  = 5;
    localparam int TQ_W     = 24;
    localparam int TV_W     = 48;
    localparam int PROD_W   = QTY_W + PRICE_W;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_EDIT   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TOTALS = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    // Commands broadcast to every cell.
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_EDIT   = 3'd2;
    localparam logic [2:0] CELL_DELETE = 3'd3;
    localparam logic [2:0] CELL_ROTATE = 3'd4;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } t_rec;

    // Command word seen by all cells.
    typedef struct packed {
        logic [2:0] op;
        t_rec       rec;
    } t_cell_cmd;

    // Compare results reported by a cell.
    typedef struct packed {
        logic eq;      // holds the command key
        logic gt;      // holds a key above the command key
        logic ins_ge;  // empty or above: new record goes here or to the left
    } t_cell_flag;

endpackage

>>> rtl/skrt_cell.sv
// One slot of the record chain: holds a record and trades it with its neighbors.
`timescale 1ns / 1ps

module skrt_cell
    import skrt_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_cmd  i_cmd,
    input  logic       i_valid,    // slot lies inside the held range
    input  logic       i_tail,     // slot is the last held one
    input  logic       i_left_ge,  // left neighbor's insert flag
    input  t_rec       i_left,
    input  t_rec       i_right,
    input  t_rec       i_wrap,     // record of the first slot, for rotation
    output t_rec       o_rec,
    output t_cell_flag o_flag
);

    t_rec r_rec;
    t_rec n_rec;

    // Key compares against the broadcast key.
    always_comb begin
        o_flag.eq     = i_valid && (r_rec.key == i_cmd.rec.key);
        o_flag.gt     = i_valid && (r_rec.key > i_cmd.rec.key);
        o_flag.ins_ge = !i_valid || (r_rec.key > i_cmd.rec.key);
    end

    // Next content of the slot.
    always_comb begin
        n_rec = r_rec;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (i_left_ge) begin
                    n_rec = i_left;
                end else if (o_flag.ins_ge) begin
                    n_rec = i_cmd.rec;
                end
            end
            CELL_EDIT: begin
                if (o_flag.eq) begin
                    n_rec.qty   = i_cmd.rec.qty;
                    n_rec.price = i_cmd.rec.price;
                end
            end
            CELL_DELETE: begin
                if (o_flag.eq || o_flag.gt) begin
                    n_rec = i_right;
                end
            end
            CELL_ROTATE: begin
                if (i_valid) begin
                    n_rec = i_tail ? i_wrap : i_right;
                end
            end
            default: n_rec = r_rec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

>>> rtl/sorted_keyed_record_table_top.sv
// Top level of the sorted keyed record table: request control around a chain of slots.
`timescale 1ns / 1ps
//
// Requests arrive on the slave stream (i_s_*): tuser carries the request code,
// tdata the key, quantity and price. Results leave on the master stream (o_m_*);
// tuser carries the status, tlast marks the final word of a request.
// The block works on one request at a time. Insert, lookup, edit and delete
// are taken in S_IDLE and done in S_EXEC, in which every slot compares its key
// at once and the chain shifts to open or close a gap. Totals and list rotate
// the held part of the chain through the first slot, one record per cycle.
// Totals also drain a multiplier stage, let the accumulators close the sums
// and then send their single word from S_TOTOUT.
// Results go through one output register; a new request is taken while a
// finished word still waits there. When the receiver stalls, the block waits
// with the next word, and a list simply pauses its rotation.
// Reset empties the table (held count zero) and clears the output; slot
// contents are not cleared.
//
module sorted_keyed_record_table_top
    import skrt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // item_key[15:0], item_quantity[36:16],
                                      // item_price_cents[60:37], zero[63:61]
    input  logic [2:0]   i_s_tuser,   // func
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,   // rec_key[15:0], rec_quantity[35:16],
                                      // rec_price_cents[58:36], entry_count[63:59],
                                      // total_quantity[87:64],
                                      // total_value_cents[135:88]
    output logic [2:0]   o_m_tuser,   // status
    output logic         o_m_tlast    // last
);

    // Control states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_LIST   = 3'd2;
    localparam logic [2:0] S_TOT    = 3'd3;
    localparam logic [2:0] S_TOTOUT = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // Registered request.
    logic [FUNC_W-1:0]   r_func;
    logic [KEY_W-1:0]    r_key;
    logic [IQTY_W-1:0]   r_qty;
    logic [IPRICE_W-1:0] r_price;

    // Totals datapath.
    logic                r_pvld, n_pvld;
    logic [QTY_W-1:0]    r_pq;
    logic [PROD_W-1:0]   r_pv;
    logic [TQ_W-1:0]     r_tq;
    logic [TV_W-1:0]     r_tv;
    logic [TQ_W:0]       tq_sum;
    logic [TV_W:0]       tv_sum;
    logic                clr_acc;

    // Output register.
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    t_rec                r_orec;
    logic [ENTRY_W-1:0]  r_oentry;
    logic [TQ_W-1:0]     r_otq;
    logic [TV_W-1:0]     r_otv;
    logic                r_olast;

    // Word being produced this cycle.
    logic                emit;
    logic [STATUS_W-1:0] e_status;
    t_rec                e_rec;
    logic                e_last;
    logic                e_tot;

    // Chain wiring.
    t_cell_cmd           cell_cmd;
    t_rec                cell_rec  [CAPACITY];
    t_cell_flag          cell_flag [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    t_rec                sel_rec;
    logic                hit;
    logic                full;
    logic                neg;
    logic                slot_free;
    logic                in_accept;

    assign in_accept  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign slot_free  = !r_ovalid || i_m_tready;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func  <= i_s_tuser;
            r_key   <= i_s_tdata[15:0];
            r_qty   <= i_s_tdata[36:16];
            r_price <= i_s_tdata[60:37];
        end
    end

    // Chain of slots.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
            t_rec left_rec;
            t_rec right_rec;
            logic left_ge;

            if (g == 0) begin : g_first
                assign left_rec = '0;
                assign left_ge  = 1'b0;
            end else begin : g_inner
                assign left_rec = cell_rec[g-1];
                assign left_ge  = cell_flag[g-1].ins_ge;
            end

            if (g == CAPACITY - 1) begin : g_end
                assign right_rec = '0;
            end else begin : g_mid
                assign right_rec = cell_rec[g+1];
            end

            skrt_cell u_cell (
                .i_clk     (i_clk),
                .i_cmd     (cell_cmd),
                .i_valid   (IDX < r_held),
                .i_tail    (IDX == (r_held - CNT_W'(1))),
                .i_left_ge (left_ge),
                .i_left    (left_rec),
                .i_right   (right_rec),
                .i_wrap    (cell_rec[0]),
                .o_rec     (cell_rec[g]),
                .o_flag    (cell_flag[g])
            );

            assign eq_vec[g] = cell_flag[g].eq;
        end
    endgenerate

    // Record of the matching slot; keys are unique, so at most one matches.
    always_comb begin
        sel_rec = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_rec = sel_rec | (cell_flag[i].eq ? cell_rec[i] : '0);
        end
    end

    assign hit  = |eq_vec;
    assign full = (r_held == CNT_W'(CAPACITY));
    assign neg  = r_qty[IQTY_W-1] || r_price[IPRICE_W-1];

    // Request sequencing and result selection.
    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_cnt        = r_cnt;
        n_pvld       = 1'b0;
        clr_acc      = 1'b0;
        cell_cmd.op  = CELL_HOLD;
        cell_cmd.rec = '{key: r_key, qty: r_qty[QTY_W-1:0], price: r_price[PRICE_W-1:0]};
        emit         = 1'b0;
        e_status     = ST_OK;
        e_rec        = '0;
        e_last       = 1'b1;
        e_tot        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    emit    = 1'b1;
                    unique case (r_func)
                        FUNC_INSERT: begin
                            if (full) begin
                                e_status = ST_FULL;
                            end else if (hit) begin
                                e_status = ST_DUPLICATE;
                            end else if (neg) begin
                                e_status = ST_INVALID;
                            end else begin
                                cell_cmd.op = CELL_INSERT;
                                n_held      = r_held + CNT_W'(1);
                                e_rec       = cell_cmd.rec;
                            end
                        end
                        FUNC_LOOKUP: begin
                            if (hit) begin
                                e_rec = sel_rec;
                            end else begin
                                e_status = ST_NOT_FOUND;
                            end
                        end
                        FUNC_EDIT: begin
                            if (!hit) begin
                                e_status = ST_NOT_FOUND;
                            end else if (neg) begin
                                e_status = ST_INVALID;
                            end else begin
                                cell_cmd.op = CELL_EDIT;
                                e_rec       = cell_cmd.rec;
                            end
                        end
                        FUNC_DELETE: begin
                            if (hit) begin
                                cell_cmd.op = CELL_DELETE;
                                n_held      = r_held - CNT_W'(1);
                                e_rec       = sel_rec;
                            end else begin
                                e_status = ST_NOT_FOUND;
                            end
                        end
                        FUNC_TOTALS: begin
                            if (r_held == '0) begin
                                e_status = ST_EMPTY;
                            end else begin
                                emit    = 1'b0;
                                clr_acc = 1'b1;
                                n_cnt   = '0;
                                n_state = S_TOT;
                            end
                        end
                        FUNC_LIST: begin
                            if (r_held == '0) begin
                                e_status = ST_EMPTY;
                            end else begin
                                emit    = 1'b0;
                                n_cnt   = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: e_status = ST_INVALID;
                    endcase
                end
            end
            S_LIST: begin
                // Past the result limit the rotation only restores the order.
                if (int'(r_cnt) >= RESULT_LIMIT || slot_free) begin
                    cell_cmd.op = CELL_ROTATE;
                    n_cnt       = r_cnt + CNT_W'(1);
                    if (int'(r_cnt) < RESULT_LIMIT) begin
                        emit   = 1'b1;
                        e_rec  = cell_rec[0];
                        e_last = (int'(r_cnt) + 1 == int'(r_held)) ||
                                 (int'(r_cnt) + 1 == RESULT_LIMIT);
                    end
                    if (n_cnt == r_held) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TOT: begin
                if (r_cnt < r_held) begin
                    cell_cmd.op = CELL_ROTATE;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_pvld      = 1'b1;
                end else if (!r_pvld) begin
                    n_state = S_TOTOUT;
                end
            end
            S_TOTOUT: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_tot   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_cnt   <= '0;
            r_pvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
            r_pvld  <= n_pvld;
        end
    end

    // Multiplier stage on the record leaving the first slot.
    always_ff @(posedge i_clk) begin
        r_pq <= cell_rec[0].qty;
        r_pv <= PROD_W'(cell_rec[0].qty) * PROD_W'(cell_rec[0].price);
    end

    // Saturating accumulators.
    assign tq_sum = {1'b0, r_tq} + (TQ_W + 1)'(r_pq);
    assign tv_sum = {1'b0, r_tv} + (TV_W + 1)'(r_pv);

    always_ff @(posedge i_clk) begin
        if (clr_acc) begin
            r_tq <= '0;
            r_tv <= '0;
        end else if (r_pvld) begin
            r_tq <= tq_sum[TQ_W] ? {TQ_W{1'b1}} : tq_sum[TQ_W-1:0];
            r_tv <= tv_sum[TV_W] ? {TV_W{1'b1}} : tv_sum[TV_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ostatus <= e_status;
            r_orec    <= e_rec;
            r_oentry  <= ENTRY_W'(n_held);
            r_otq     <= e_tot ? r_tq : '0;
            r_otv     <= e_tot ? r_tv : '0;
            r_olast   <= e_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {r_otv, r_otq, r_oentry, r_orec.price, r_orec.qty, r_orec.key};

    // The held count changes only while a single-step request completes.
    a_held_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> $stable(r_held))
        else $error("held count changed outside a request step");

    // The table never holds more records than it has slots.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    // Held keys stay unique, so a compare never hits two slots.
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(eq_vec))
        else $error("key held in more than one slot");

    // An accepted request is worked on in the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

endmodule

>>> tb/sorted_keyed_record_table_top_test.sv
// Self-checking testbench of the sorted keyed record table: directed table, then random traffic.
`timescale 1ns / 1ps

module sorted_keyed_record_table_top_test;
    import skrt_pkg::*;

    // Request codes the block does not define; both must answer as invalid.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 245;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    // One result word, split into its fields.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [QTY_W-1:0]    qty;
        logic [PRICE_W-1:0]  price;
        logic [ENTRY_W-1:0]  count;
        logic [TQ_W-1:0]     tq;
        logic [TV_W-1:0]     tv;
        logic                last;
    } t_result_word;

    // One row of directed stimulus; typed rows carry their expected status and count.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [IQTY_W-1:0]   qty;
        logic [IPRICE_W-1:0] price;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  count;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 25;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // Empty table right after reset.
        '{FUNC_TOTALS,  16'h0000, 21'd0,        24'd0,        1'b1, ST_EMPTY,     5'd0},
        '{FUNC_LIST,    16'h0000, 21'd0,        24'd0,        1'b1, ST_EMPTY,     5'd0},
        '{FUNC_LOOKUP,  16'h0005, 21'd0,        24'd0,        1'b1, ST_NOT_FOUND, 5'd0},
        '{FUNC_EDIT,    16'h0005, 21'd10,       24'd10,       1'b1, ST_NOT_FOUND, 5'd0},
        '{FUNC_DELETE,  16'h0005, 21'd0,        24'd0,        1'b1, ST_NOT_FOUND, 5'd0},
        '{FUNC_SPARE_6, 16'h1234, 21'd1,        24'd1,        1'b1, ST_INVALID,   5'd0},
        '{FUNC_SPARE_7, 16'hFFFF, 21'h1FFFFF,   24'hFFFFFF,   1'b1, ST_INVALID,   5'd0},
        // Negative quantity, then negative price.
        '{FUNC_INSERT,  16'h0007, 21'h100000,   24'd100,      1'b1, ST_INVALID,   5'd0},
        '{FUNC_INSERT,  16'h0007, 21'd1,        24'h800000,   1'b1, ST_INVALID,   5'd0},
        // Extremes of key and values.
        '{FUNC_INSERT,  16'hFFFF, 21'h0FFFFF,   24'h7FFFFF,   1'b0, ST_OK,        5'd0},
        '{FUNC_INSERT,  16'h0000, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        // Duplicate wins over an invalid value.
        '{FUNC_INSERT,  16'h0000, 21'h1FFFFF,   24'hFFFFFF,   1'b1, ST_DUPLICATE, 5'd2},
        '{FUNC_INSERT,  16'h8000, 21'h0FFFFF,   24'h7FFFFF,   1'b0, ST_OK,        5'd0},
        '{FUNC_INSERT,  16'h0100, 21'd3,        24'd250,      1'b0, ST_OK,        5'd0},
        '{FUNC_LOOKUP,  16'hFFFF, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        '{FUNC_LOOKUP,  16'h0000, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        // Edit with a bad value leaves the record alone.
        '{FUNC_EDIT,    16'h8000, 21'd5,        24'hFFFFFF,   1'b1, ST_INVALID,   5'd4},
        '{FUNC_EDIT,    16'h8000, 21'd12,       24'd1999,     1'b0, ST_OK,        5'd0},
        '{FUNC_EDIT,    16'h1234, 21'd1,        24'd1,        1'b1, ST_NOT_FOUND, 5'd4},
        '{FUNC_TOTALS,  16'h0000, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        '{FUNC_LIST,    16'h0000, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        // Remove the first and the last record.
        '{FUNC_DELETE,  16'h0000, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        '{FUNC_DELETE,  16'hFFFF, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0},
        '{FUNC_DELETE,  16'hFFFF, 21'd0,        24'd0,        1'b1, ST_NOT_FOUND, 5'd2},
        '{FUNC_LIST,    16'h0000, 21'd0,        24'd0,        1'b0, ST_OK,        5'd0}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata;   // item_key[15:0], item_quantity[36:16],
                               // item_price_cents[60:37], zero[63:61]
    logic [2:0]   i_s_tuser;   // func
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [135:0] o_m_tdata;   // rec_key[15:0], rec_quantity[35:16],
                               // rec_price_cents[58:36], entry_count[63:59],
                               // total_quantity[87:64], total_value_cents[135:88]
    logic [2:0]   o_m_tuser;   // status
    logic         o_m_tlast;   // last

    // Shadow copy of the table, sorted by key.
    logic [KEY_W-1:0]   shadow_key   [CAPACITY];
    logic [QTY_W-1:0]   shadow_qty   [CAPACITY];
    logic [PRICE_W-1:0] shadow_price [CAPACITY];
    int                 shadow_held;

    t_result_word awaited_words [$];
    int           mismatch_cnt;
    int           cycle_cnt;
    bit           steady_stretch;

    sorted_keyed_record_table_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and queue the words it should produce.
    function automatic void apply_table_request(input logic [FUNC_W-1:0] func,
                                                input logic [KEY_W-1:0] key,
                                                input logic [IQTY_W-1:0] qty_in,
                                                input logic [IPRICE_W-1:0] price_in);
        t_result_word w;
        int           hit;
        int           slot;
        int           n;
        logic [63:0]  sum_q;
        logic [63:0]  sum_v;
        logic         bad_value;
        w         = '0;
        w.last    = 1'b1;
        bad_value = qty_in[IQTY_W-1] | price_in[IPRICE_W-1];
        hit       = -1;
        for (int i = 0; i < shadow_held; i++) begin
            if (shadow_key[i] == key) hit = i;
        end

        case (func)
            FUNC_INSERT: begin
                if (shadow_held >= CAPACITY) begin
                    w.status = ST_FULL;
                end else if (hit >= 0) begin
                    w.status = ST_DUPLICATE;
                end else if (bad_value) begin
                    w.status = ST_INVALID;
                end else begin
                    slot = 0;
                    while (slot < shadow_held && shadow_key[slot] < key) slot++;
                    for (int i = shadow_held; i > slot; i--) begin
                        shadow_key[i]   = shadow_key[i-1];
                        shadow_qty[i]   = shadow_qty[i-1];
                        shadow_price[i] = shadow_price[i-1];
                    end
                    shadow_key[slot]   = key;
                    shadow_qty[slot]   = qty_in[QTY_W-1:0];
                    shadow_price[slot] = price_in[PRICE_W-1:0];
                    shadow_held++;
                    w.status = ST_OK;
                    w.key    = key;
                    w.qty    = qty_in[QTY_W-1:0];
                    w.price  = price_in[PRICE_W-1:0];
                end
            end
            FUNC_LOOKUP: begin
                if (hit < 0) begin
                    w.status = ST_NOT_FOUND;
                end else begin
                    w.status = ST_OK;
                    w.key    = key;
                    w.qty    = shadow_qty[hit];
                    w.price  = shadow_price[hit];
                end
            end
            FUNC_EDIT: begin
                if (hit < 0) begin
                    w.status = ST_NOT_FOUND;
                end else if (bad_value) begin
                    w.status = ST_INVALID;
                end else begin
                    shadow_qty[hit]   = qty_in[QTY_W-1:0];
                    shadow_price[hit] = price_in[PRICE_W-1:0];
                    w.status = ST_OK;
                    w.key    = key;
                    w.qty    = qty_in[QTY_W-1:0];
                    w.price  = price_in[PRICE_W-1:0];
                end
            end
            FUNC_DELETE: begin
                if (hit < 0) begin
                    w.status = ST_NOT_FOUND;
                end else begin
                    w.status = ST_OK;
                    w.key    = key;
                    w.qty    = shadow_qty[hit];
                    w.price  = shadow_price[hit];
                    for (int i = hit; i + 1 < shadow_held; i++) begin
                        shadow_key[i]   = shadow_key[i+1];
                        shadow_qty[i]   = shadow_qty[i+1];
                        shadow_price[i] = shadow_price[i+1];
                    end
                    shadow_held--;
                end
            end
            FUNC_TOTALS: begin
                if (shadow_held == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    sum_q = '0;
                    sum_v = '0;
                    for (int i = 0; i < shadow_held; i++) begin
                        sum_q += 64'(shadow_qty[i]);
                        sum_v += 64'(shadow_qty[i]) * 64'(shadow_price[i]);
                    end
                    // Both sums saturate at the top of their fields.
                    if (sum_q > 64'hFFFFFF) sum_q = 64'hFFFFFF;
                    if (sum_v > 64'hFFFF_FFFF_FFFF) sum_v = 64'hFFFF_FFFF_FFFF;
                    w.status = ST_OK;
                    w.tq     = sum_q[TQ_W-1:0];
                    w.tv     = sum_v[TV_W-1:0];
                end
            end
            FUNC_LIST: begin
                if (shadow_held == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    n = (shadow_held > RESULT_LIMIT) ? RESULT_LIMIT : shadow_held;
                    for (int i = 0; i < n; i++) begin
                        w.status = ST_OK;
                        w.key    = shadow_key[i];
                        w.qty    = shadow_qty[i];
                        w.price  = shadow_price[i];
                        w.count  = ENTRY_W'(shadow_held);
                        w.last   = (i == n - 1);
                        awaited_words.push_back(w);
                    end
                    return;
                end
            end
            default: begin
                w.status = ST_INVALID;
            end
        endcase
        w.count = ENTRY_W'(shadow_held);
        awaited_words.push_back(w);
    endfunction

    // Offer one request word, idling first at random, and predict once it is taken.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                                input logic [IQTY_W-1:0] qty, input logic [IPRICE_W-1:0] price,
                                input logic typed, input t_result_word typed_word);
        while (!steady_stretch && $urandom_range(99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {3'b000, price, qty, key};
        do @(posedge i_clk); while (!o_s_tready);
        apply_table_request(func, key, qty, price);
        // A typed row replaces the predicted word with the one written in the table.
        if (typed) begin
            void'(awaited_words.pop_back());
            awaited_words.push_back(typed_word);
        end
    endtask

    // Stop offering requests until every awaited word has come back.
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random back-pressure and the comparison of each word taken.
    initial begin
        t_result_word got;
        t_result_word want;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.status = o_m_tuser;
                got.key    = o_m_tdata[15:0];
                got.qty    = o_m_tdata[35:16];
                got.price  = o_m_tdata[58:36];
                got.count  = o_m_tdata[63:59];
                got.tq     = o_m_tdata[87:64];
                got.tv     = o_m_tdata[135:88];
                got.last   = o_m_tlast;
                if (awaited_words.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected word: status %0d key %h", got.status, got.key);
                end else begin
                    want = awaited_words.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected st %0d key %h qty %h price %h",
                                     want.status, want.key, want.qty, want.price);
                            $display("          cnt %0d tq %h tv %h last %b",
                                     want.count, want.tq, want.tv, want.last);
                            $display("          actual st %0d key %h qty %h price %h",
                                     got.status, got.key, got.qty, got.price);
                            $display("          cnt %0d tq %h tv %h last %b",
                                     got.count, got.tq, got.tv, got.last);
                        end
                    end
                end
            end
            i_m_tready <= steady_stretch || ($urandom_range(99) >= 36);
        end
    end

    // Watchdog.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("sorted_keyed_record_table_top regression: fail");
        $finish;
    end

    // Request side: reset, directed rows, then random traffic in fill and drain phases.
    initial begin
        t_result_word        typed_w;
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [IQTY_W-1:0]   qty;
        logic [IPRICE_W-1:0] price;
        logic [31:0]         raw;
        int                  pick;
        bit                  filling;

        mismatch_cnt   = 0;
        shadow_held    = 0;
        steady_stretch = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= FUNC_INSERT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (DIRECTED[i]) begin
            typed_w        = '0;
            typed_w.status = DIRECTED[i].status;
            typed_w.count  = DIRECTED[i].count;
            typed_w.last   = 1'b1;
            send_request(DIRECTED[i].func, DIRECTED[i].key, DIRECTED[i].qty,
                         DIRECTED[i].price, DIRECTED[i].typed, typed_w);
        end

        // Random part: insert-heavy phases fill the table, delete-heavy ones empty it.
        typed_w = '0;
        for (int r = 0; r < RANDOM_ITEMS; r++) begin
            steady_stretch = (r >= 90 && r < 150);
            if (r == 200) hold_until_drained();
            filling = ((r / 45) % 2) == 0;
            pick    = $urandom_range(99);
            if (filling) begin
                if      (pick < 65) func = FUNC_INSERT;
                else if (pick < 73) func = FUNC_LOOKUP;
                else if (pick < 81) func = FUNC_EDIT;
                else if (pick < 86) func = FUNC_DELETE;
                else if (pick < 92) func = FUNC_TOTALS;
                else if (pick < 97) func = FUNC_LIST;
                else                func = pick[0] ? FUNC_SPARE_7 : FUNC_SPARE_6;
            end else begin
                if      (pick < 15) func = FUNC_INSERT;
                else if (pick < 30) func = FUNC_LOOKUP;
                else if (pick < 42) func = FUNC_EDIT;
                else if (pick < 75) func = FUNC_DELETE;
                else if (pick < 83) func = FUNC_TOTALS;
                else if (pick < 93) func = FUNC_LIST;
                else                func = pick[0] ? FUNC_SPARE_7 : FUNC_SPARE_6;
            end

            // Keys mostly hit held records or a small pool, sometimes anywhere.
            pick = $urandom_range(99);
            if (func != FUNC_INSERT && shadow_held > 0 && pick < 60)
                key = shadow_key[$urandom_range(shadow_held - 1)];
            else if (pick < 85)
                key = KEY_W'($urandom_range(47));
            else
                key = KEY_W'($urandom());

            // Values are mostly valid; a negative one now and then.
            raw = $urandom();
            qty = ($urandom_range(99) < 7) ? {1'b1, raw[19:0]} : {1'b0, raw[19:0]};
            raw = $urandom();
            price = ($urandom_range(99) < 7) ? {1'b1, raw[22:0]} : {1'b0, raw[22:0]};

            send_request(func, key, qty, price, 1'b0, typed_w);
        end

        // Wind down: collect everything, then watch for stray words.
        steady_stretch = 1'b0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && awaited_words.size() == 0) begin
            $display("sorted_keyed_record_table_top regression: pass");
        end else begin
            $display("sorted_keyed_record_table_top regression: fail");
        end
        $finish;
    end

endmodule
